// ===== rtl/hrlf_pkg.sv =====
// Shared types, codes and helpers for the HTTP response length framer.
package hrlf_pkg;

  typedef enum logic [2:0] {
    PH_HDR   = 3'd0,
    PH_CLEN  = 3'd1,
    PH_TENC  = 3'd2,
    PH_DATA  = 3'd3,
    PH_CSIZE = 3'd4
  } phase_t;

  localparam logic [2:0] K_HDR       = 3'd0;
  localparam logic [2:0] K_FRAME     = 3'd1;
  localparam logic [2:0] K_PAY       = 3'd2;
  localparam logic [2:0] K_PAY_END   = 3'd3;
  localparam logic [2:0] K_FRAME_END = 3'd4;
  localparam logic [2:0] K_ERR       = 3'd5;
  localparam logic [2:0] K_REJ       = 3'd6;

  localparam logic [7:0] CH_CR  = 8'h0d;
  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;

  // Byte class computed in the front stage.
  typedef struct packed {
    logic [7:0] raw;
    logic [7:0] lc;
    logic       is_cr;
    logic       is_lf;
    logic       is_ws;
    logic       is_dig;
    logic       is_hex;
    logic [3:0] hval;
  } cls_t;

  function automatic logic [7:0] key_chr(input logic [1:0] k, input logic [4:0] p);
    logic [7:0] r;
    r = 8'h00;
    case (k)
      2'd0: begin
        case (p)
          5'd0: r = CH_CR; 5'd1: r = CH_LF; 5'd2: r = "c"; 5'd3: r = "o";
          5'd4: r = "n"; 5'd5: r = "t"; 5'd6: r = "e"; 5'd7: r = "n";
          5'd8: r = "t"; 5'd9: r = "-"; 5'd10: r = "l"; 5'd11: r = "e";
          5'd12: r = "n"; 5'd13: r = "g"; 5'd14: r = "t"; 5'd15: r = "h";
          5'd16: r = ":";
          default: r = 8'h00;
        endcase
      end
      2'd1: begin
        case (p)
          5'd0: r = CH_CR; 5'd1: r = CH_LF; 5'd2: r = "t"; 5'd3: r = "r";
          5'd4: r = "a"; 5'd5: r = "n"; 5'd6: r = "s"; 5'd7: r = "f";
          5'd8: r = "e"; 5'd9: r = "r"; 5'd10: r = "-"; 5'd11: r = "e";
          5'd12: r = "n"; 5'd13: r = "c"; 5'd14: r = "o"; 5'd15: r = "d";
          5'd16: r = "i"; 5'd17: r = "n"; 5'd18: r = "g"; 5'd19: r = ":";
          default: r = 8'h00;
        endcase
      end
      2'd2: begin
        case (p)
          5'd0: r = CH_CR; 5'd1: r = CH_LF; 5'd2: r = CH_CR; 5'd3: r = CH_LF;
          default: r = 8'h00;
        endcase
      end
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] key_len(input logic [1:0] k);
    logic [4:0] r;
    case (k)
      2'd0: r = 5'd17;
      2'd1: r = 5'd20;
      default: r = 5'd4;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] chunked_chr(input logic [3:0] p);
    logic [7:0] r;
    case (p)
      4'd0: r = "c"; 4'd1: r = "h"; 4'd2: r = "u"; 4'd3: r = "n";
      4'd4: r = "k"; 4'd5: r = "e"; 4'd6: r = "d";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/hrlf_front.sv =====
// Front stage: takes input beats and classifies each byte.
module hrlf_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_data_byte,
  output logic                q_valid,
  input  logic                q_stall,
  output hrlf_pkg::cls_t      q_cls
);
  import hrlf_pkg::*;

  cls_t       cls_nxt;
  logic [7:0] lc;

  always_comb begin
    lc = (in_data_byte >= "A" && in_data_byte <= "Z") ? in_data_byte + 8'd32 : in_data_byte;
    cls_nxt.raw    = in_data_byte;
    cls_nxt.lc     = lc;
    cls_nxt.is_cr  = (in_data_byte == CH_CR);
    cls_nxt.is_lf  = (in_data_byte == CH_LF);
    cls_nxt.is_ws  = (in_data_byte == CH_SP) || (in_data_byte == CH_TAB);
    cls_nxt.is_dig = (in_data_byte >= "0") && (in_data_byte <= "9");
    cls_nxt.is_hex = cls_nxt.is_dig || ((lc >= "a") && (lc <= "f"));
    cls_nxt.hval   = cls_nxt.is_dig ? 4'(in_data_byte - "0") : 4'(lc - "a" + 8'd10);
  end

  // Two-entry queue toward the back stage.
  cls_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && !q_stall;
  assign q_cls    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) mem_r[wp_r] <= cls_nxt;
  end
endmodule

// ===== rtl/hrlf_back.sv =====
// Back stage: framing state machine with a registered result beat.
module hrlf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_stall,
  input  hrlf_pkg::cls_t      q_cls,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          out_kind,
  output logic [7:0]          out_echo_byte,
  output logic [31:0]         out_bytes_left,
  output logic                out_is_chunked
);
  import hrlf_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  sub_r, sub_nxt;
  logic [4:0]  kpos_r, kpos_nxt;
  logic [2:0]  kcand_r, kcand_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic        lknown_r, lknown_nxt;
  logic        chunk_r, chunk_nxt;
  logic        begun_r, begun_nxt;
  logic        fin_r, fin_nxt;
  logic        fail_r, fail_nxt;
  logic        ov_r;
  logic [2:0]  kind;
  logic [2:0]  allow, nm;
  logic [4:0]  kp1;
  logic        take;
  logic [35:0] mul10;
  logic [32:0] dsum;

  assign q_stall = out_valid && out_stall;
  assign take    = q_valid && !q_stall;

  always_comb begin
    phase_nxt = phase_r; sub_nxt = sub_r; kpos_nxt = kpos_r; kcand_nxt = kcand_r;
    rem_nxt = rem_r; lknown_nxt = lknown_r; chunk_nxt = chunk_r; begun_nxt = begun_r;
    fin_nxt = fin_r; fail_nxt = fail_r; kind = K_HDR;
    allow = lknown_r ? 3'b100 : 3'b111;
    nm = 3'b000;
    kp1 = kpos_r + 5'd1;
    mul10 = {4'd0, rem_r} * 36'd10;
    dsum = {1'b0, mul10[31:0]} + {29'd0, q_cls.hval};
    for (int k = 0; k < 3; k++) begin
      if (kcand_r[k] && allow[k] && kpos_r < key_len(2'(k)) &&
          key_chr(2'(k), kpos_r) == q_cls.lc) nm[k] = 1'b1;
    end
    if (fail_r) kind = K_ERR;
    else if (fin_r) kind = K_REJ;
    else begin
      unique case (phase_r)
        PH_HDR: begin
          if (nm == 3'b000) begin
            kpos_nxt = q_cls.is_cr ? 5'd1 : 5'd0;
            kcand_nxt = allow;
          end else begin
            kpos_nxt = kp1;
            kcand_nxt = nm;
            if (nm[0] && kp1 == 5'd17) begin
              kpos_nxt = '0; kcand_nxt = allow; sub_nxt = '0;
              phase_nxt = PH_CLEN; rem_nxt = '0;
            end else if (nm[1] && kp1 == 5'd20) begin
              kpos_nxt = '0; kcand_nxt = allow; sub_nxt = '0;
              phase_nxt = PH_TENC;
            end else if (nm[2] && kp1 == 5'd4) begin
              kpos_nxt = '0; kcand_nxt = allow; sub_nxt = '0;
              begun_nxt = 1'b1;
              if (chunk_r) begin
                phase_nxt = PH_CSIZE; rem_nxt = '0;
              end else if (rem_r == '0) begin
                fin_nxt = 1'b1; kind = K_FRAME_END;
              end else phase_nxt = PH_DATA;
            end
          end
        end
        PH_CLEN: begin
          if (sub_r == 4'd0 && q_cls.is_ws) kind = K_HDR;
          else if (sub_r <= 4'd1) begin
            if (q_cls.is_dig) begin
              if (ov_r || dsum[32]) begin
                fail_nxt = 1'b1; kind = K_ERR;
              end else begin
                rem_nxt = dsum[31:0]; sub_nxt = 4'd1;
              end
            end else if (q_cls.is_cr) sub_nxt = 4'd3;
            else begin
              fail_nxt = 1'b1; kind = K_ERR;
            end
          end else if (sub_r == 4'd3 && q_cls.is_lf) begin
            lknown_nxt = 1'b1;
            phase_nxt = PH_HDR; sub_nxt = '0; kpos_nxt = 5'd2; kcand_nxt = 3'b100;
          end else begin
            fail_nxt = 1'b1; kind = K_ERR;
          end
        end
        PH_TENC: begin
          if (sub_r <= 4'd6) begin
            if (!(sub_r == 4'd0 && q_cls.is_ws)) begin
              if (q_cls.lc == chunked_chr(sub_r)) sub_nxt = sub_r + 4'd1;
              else sub_nxt = q_cls.is_cr ? 4'd10 : 4'd8;
            end
          end else begin
            case (sub_r)
              4'd7: begin
                if (q_cls.is_cr) sub_nxt = 4'd9;
                else if (!q_cls.is_ws) sub_nxt = 4'd8;
              end
              4'd8: if (q_cls.is_cr) sub_nxt = 4'd10;
              4'd9, 4'd10: begin
                if (!q_cls.is_lf) begin
                  fail_nxt = 1'b1; kind = K_ERR;
                end else begin
                  if (sub_r == 4'd9) begin
                    chunk_nxt = 1'b1; lknown_nxt = 1'b1; rem_nxt = '0;
                  end
                  phase_nxt = PH_HDR; sub_nxt = '0; kpos_nxt = 5'd2;
                  kcand_nxt = (lknown_r || sub_r == 4'd9) ? 3'b100 : 3'b111;
                end
              end
              default: begin
                fail_nxt = 1'b1; kind = K_ERR;
              end
            endcase
          end
        end
        PH_DATA: begin
          rem_nxt = (rem_r != '0) ? rem_r - 32'd1 : '0;
          kind = K_PAY;
          if (rem_nxt == '0) begin
            if (chunk_r) begin
              phase_nxt = PH_CSIZE; sub_nxt = '0;
            end else begin
              fin_nxt = 1'b1; kind = K_PAY_END;
            end
          end
        end
        PH_CSIZE: begin
          kind = K_FRAME;
          if (sub_r == 4'd0 && q_cls.is_cr) sub_nxt = 4'd1;
          else if (sub_r == 4'd1) begin
            if (!q_cls.is_lf) begin
              fail_nxt = 1'b1; kind = K_ERR;
            end else sub_nxt = 4'd2;
          end else if (sub_r == 4'd0 || sub_r == 4'd2) begin
            sub_nxt = 4'd2;
            if (q_cls.is_hex) begin
              if (rem_r[31:28] != 4'd0) begin
                fail_nxt = 1'b1; kind = K_ERR;
              end else rem_nxt = {rem_r[27:0], q_cls.hval};
            end else if (q_cls.is_ws) sub_nxt = 4'd3;
            else if (q_cls.is_cr) sub_nxt = 4'd5;
            else begin
              fail_nxt = 1'b1; kind = K_ERR;
            end
          end else if (sub_r == 4'd3) begin
            if (q_cls.is_cr) sub_nxt = 4'd5;
            else if (!q_cls.is_ws) begin
              fail_nxt = 1'b1; kind = K_ERR;
            end
          end else if (sub_r == 4'd5 && q_cls.is_lf) begin
            sub_nxt = '0;
            if (rem_r == '0) begin
              fin_nxt = 1'b1; kind = K_FRAME_END;
            end else phase_nxt = PH_DATA;
          end else begin
            fail_nxt = 1'b1; kind = K_ERR;
          end
        end
        default: begin
          fail_nxt = 1'b1; kind = K_ERR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR; sub_r <= '0; kpos_r <= '0; kcand_r <= 3'b111;
      rem_r <= '0; lknown_r <= 1'b0; chunk_r <= 1'b0; begun_r <= 1'b0;
      fin_r <= 1'b0; fail_r <= 1'b0; ov_r <= 1'b0; out_valid <= 1'b0;
    end else begin
      if (take) begin
        phase_r <= phase_nxt; sub_r <= sub_nxt; kpos_r <= kpos_nxt;
        kcand_r <= kcand_nxt; rem_r <= rem_nxt; lknown_r <= lknown_nxt;
        chunk_r <= chunk_nxt; begun_r <= begun_nxt; fin_r <= fin_nxt;
        fail_r <= fail_nxt;
        // rem*10 overflow flag for the next decimal digit
        ov_r <= ({4'd0, rem_nxt} * 36'd10) > 36'hFFFFFFFF;
        out_valid <= 1'b1;
      end else if (!out_stall) out_valid <= 1'b0;
    end
    if (take) begin
      out_kind       <= kind;
      out_echo_byte  <= q_cls.raw;
      out_bytes_left <= (!fail_nxt && !fin_nxt && phase_nxt == PH_DATA) ? rem_nxt : '0;
      out_is_chunked <= chunk_nxt;
    end
  end
endmodule

// ===== rtl/http_response_length_framer_top.sv =====
// Top level of the HTTP response length framer.
// One result beat per input byte; one byte per clock sustained while out_stall
// is low. A classify stage with a two-entry queue feeds the framing state
// machine that registers the result. kind tells header, framing, payload,
// completion, sticky error or rejection after completion; bytes_left counts
// body or chunk bytes still due. Reset is needed between responses.
module http_response_length_framer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_echo_byte,
  output logic [31:0] out_bytes_left,
  output logic        out_is_chunked
);
  import hrlf_pkg::*;

  logic q_valid, q_stall;
  cls_t q_cls;

  hrlf_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data_byte,
    .q_valid, .q_stall, .q_cls
  );

  hrlf_back u_back (
    .clk, .rst_n, .q_valid, .q_stall, .q_cls,
    .out_valid, .out_stall, .out_kind, .out_echo_byte, .out_bytes_left, .out_is_chunked
  );
endmodule

// ===== rtl/hrlf_checker.sv =====
// Port-level checks for the framer, bound to the top level.
module hrlf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_kind,
  input logic [31:0] out_bytes_left,
  input logic        out_is_chunked
);
  import hrlf_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind))
    else $error("stalled beat changed");

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_kind == K_ERR ##1 out_valid |-> out_kind == K_ERR)
    else $error("error not sticky");

  a_left_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == K_PAY_END || out_kind == K_FRAME_END ||
                  out_kind == K_ERR || out_kind == K_REJ)
    |-> out_bytes_left == 32'd0)
    else $error("bytes_left not zero");

  a_chunk_keep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_is_chunked ##1 out_valid |-> out_is_chunked)
    else $error("chunked flag dropped");
endmodule

bind http_response_length_framer_top hrlf_checker u_chk (
  .clk, .rst_n, .out_valid, .out_stall, .out_kind, .out_bytes_left, .out_is_chunked
);

// ===== bench/tb_top.sv =====
// Self-checking testbench for the HTTP response length framer: one framed response per run.
`timescale 1ns / 100ps
module tb_top;
  import hrlf_pkg::*;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  echo;
    logic [31:0] left;
    logic        chunked;
  } beat_t;

  logic        clk, rst_n;
  logic        in_valid, in_stall, out_valid, out_stall, out_is_chunked;
  logic [7:0]  in_data_byte, out_echo_byte;
  logic [2:0]  out_kind;
  logic [31:0] out_bytes_left;

  http_response_length_framer_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data_byte(in_data_byte),
    .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
    .out_echo_byte(out_echo_byte), .out_bytes_left(out_bytes_left),
    .out_is_chunked(out_is_chunked)
  );

  // framer state mirror
  phase_t      ph;
  logic [3:0]  sub;
  int          kpos;
  logic [2:0]  kcand;
  logic [31:0] rem;
  bit          len_known, chunk_mode, done, bad;
  string       keys[3] = '{"\015\012content-length:", "\015\012transfer-encoding:",
                           "\015\012\015\012"};
  string       word = "chunked";

  logic [7:0]  byte_stream[$];
  beat_t       due_beats[$];
  int          errors, beats_seen, scenario;
  bit          took_in, all_queued;
  int          in_gap, stall_left;
  bit          in_burst, out_burst;

  function automatic logic [7:0] lower(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic bit is_ws(input logic [7:0] c);
    return c == CH_SP || c == CH_TAB;
  endfunction

  function logic [2:0] fail_now();
    bad = 1;
    return K_ERR;
  endfunction

  function void line_end();
    ph = PH_HDR;
    sub = 0;
    kpos = 2;
    kcand = len_known ? 3'b100 : 3'b111;
  endfunction

  function logic [2:0] frame_hdr(input logic [7:0] c);
    logic [2:0] allow, nm;
    allow = len_known ? 3'b100 : 3'b111;
    nm = 0;
    for (int k = 0; k < 3; k++)
      if (kcand[k] && allow[k] && kpos < keys[k].len() && keys[k][kpos] == lower(c))
        nm[k] = 1;
    if (nm == 0) begin
      kpos = (c == CH_CR) ? 1 : 0;
      kcand = allow;
      return K_HDR;
    end
    kpos++;
    kcand = nm;
    for (int k = 0; k < 3; k++) begin
      if (nm[k] && keys[k].len() == kpos) begin
        kpos = 0;
        kcand = allow;
        sub = 0;
        if (k == 0) begin
          ph = PH_CLEN;
          rem = 0;
        end else if (k == 1) begin
          ph = PH_TENC;
        end else begin
          if (chunk_mode) begin
            ph = PH_CSIZE;
            rem = 0;
          end else if (rem == 0) begin
            done = 1;
            return K_FRAME_END;
          end else begin
            ph = PH_DATA;
          end
        end
        return K_HDR;
      end
    end
    return K_HDR;
  endfunction

  function logic [2:0] frame_clen(input logic [7:0] c);
    logic [31:0] d;
    if (sub == 0 && is_ws(c)) return K_HDR;
    if (sub <= 1) begin
      if (c >= "0" && c <= "9") begin
        d = c - "0";
        if (rem > (32'hffff_ffff - d) / 10) return fail_now();
        rem = rem * 10 + d;
        sub = 1;
        return K_HDR;
      end
      if (c == CH_CR) begin
        sub = 3;
        return K_HDR;
      end
      return fail_now();
    end
    if (sub == 3 && c == CH_LF) begin
      len_known = 1;
      line_end();
      return K_HDR;
    end
    return fail_now();
  endfunction

  function logic [2:0] frame_tenc(input logic [7:0] c);
    if (sub <= 6) begin
      if (sub == 0 && is_ws(c)) return K_HDR;
      if (lower(c) == word[sub]) sub++;
      else sub = (c == CH_CR) ? 4'd10 : 4'd8;
      return K_HDR;
    end
    case (sub)
      4'd7: begin
        if (c == CH_CR) sub = 9;
        else if (!is_ws(c)) sub = 8;
        return K_HDR;
      end
      4'd8: begin
        if (c == CH_CR) sub = 10;
        return K_HDR;
      end
      4'd9: begin
        if (c != CH_LF) return fail_now();
        chunk_mode = 1;
        len_known = 1;
        rem = 0;
        line_end();
        return K_HDR;
      end
      4'd10: begin
        if (c != CH_LF) return fail_now();
        line_end();
        return K_HDR;
      end
      default: return fail_now();
    endcase
  endfunction

  function logic [2:0] frame_payload();
    rem = (rem != 0) ? rem - 1 : 0;
    if (chunk_mode) begin
      if (rem == 0) begin
        ph = PH_CSIZE;
        sub = 0;
      end
      return K_PAY;
    end
    if (rem == 0) begin
      done = 1;
      return K_PAY_END;
    end
    return K_PAY;
  endfunction

  function logic [2:0] frame_csize(input logic [7:0] c);
    logic [7:0]  lc;
    logic [31:0] v;
    if (sub == 0) begin
      if (c == CH_CR) begin
        sub = 1;
        return K_FRAME;
      end
      sub = 2;
    end else if (sub == 1) begin
      if (c != CH_LF) return fail_now();
      sub = 2;
      return K_FRAME;
    end
    if (sub == 2) begin
      lc = lower(c);
      if (lc >= "0" && lc <= "9") v = lc - "0";
      else if (lc >= "a" && lc <= "f") v = lc - "a" + 10;
      else if (is_ws(c)) begin
        sub = 3;
        return K_FRAME;
      end else if (c == CH_CR) begin
        sub = 5;
        return K_FRAME;
      end else return fail_now();
      if (rem > 32'h0fff_ffff) return fail_now();
      rem = (rem << 4) | v;
      return K_FRAME;
    end
    if (sub == 3) begin
      if (is_ws(c)) return K_FRAME;
      if (c == CH_CR) begin
        sub = 5;
        return K_FRAME;
      end
      return fail_now();
    end
    if (sub == 5 && c == CH_LF) begin
      sub = 0;
      if (rem == 0) begin
        done = 1;
        return K_FRAME_END;
      end
      ph = PH_DATA;
      return K_FRAME;
    end
    return fail_now();
  endfunction

  function beat_t frame_byte(input logic [7:0] c);
    beat_t b;
    if (bad) b.kind = K_ERR;
    else if (done) b.kind = K_REJ;
    else begin
      case (ph)
        PH_HDR:   b.kind = frame_hdr(c);
        PH_CLEN:  b.kind = frame_clen(c);
        PH_TENC:  b.kind = frame_tenc(c);
        PH_DATA:  b.kind = frame_payload();
        PH_CSIZE: b.kind = frame_csize(c);
        default:  b.kind = fail_now();
      endcase
    end
    b.echo = c;
    b.left = (!bad && !done && ph == PH_DATA) ? rem : 32'd0;
    b.chunked = chunk_mode;
    return b;
  endfunction

  task report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("mismatch beat %0d %s: got %0h want %0h", beats_seen, what, got, want);
  endtask

  task put(input string s);
    for (int i = 0; i < s.len(); i++) byte_stream.push_back(s[i]);
  endtask

  function automatic string mix_case(input string s);
    string r;
    r = s;
    for (int i = 0; i < r.len(); i++)
      if ($urandom_range(0, 1)) r[i] = (r[i] >= "a" && r[i] <= "z") ? r[i] - 8'd32 : r[i];
    return r;
  endfunction

  task put_random(input int n);
    for (int i = 0; i < n; i++) byte_stream.push_back($urandom_range(0, 255));
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // drive at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
      in_data_byte <= 0;
      out_stall <= 0;
    end else begin
      if (!in_valid || took_in) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 0;
        end else if (byte_stream.size() > 0) begin
          in_data_byte <= byte_stream.pop_front();
          in_valid <= 1;
          if ($urandom_range(0, 40) == 0) in_burst = !in_burst;
          in_gap = in_burst ? 0 : $urandom_range(0, 4);
        end else begin
          in_valid <= 0;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1;
      end else begin
        out_stall <= 0;
        if ($urandom_range(0, 40) == 0) out_burst = !out_burst;
        stall_left = out_burst ? 0 : $urandom_range(0, 4);
      end
    end
  end

  // sample at the rising edge
  always @(posedge clk) begin
    beat_t w;
    took_in = 0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        beats_seen++;
        if (due_beats.size() == 0) begin
          report("unexpected beat", out_kind, 0);
        end else begin
          w = due_beats.pop_front();
          if (out_kind !== w.kind) report("kind", out_kind, w.kind);
          if (out_echo_byte !== w.echo) report("echo_byte", out_echo_byte, w.echo);
          if (out_bytes_left !== w.left) report("bytes_left", out_bytes_left, w.left);
          if (out_is_chunked !== w.chunked) report("is_chunked", out_is_chunked, w.chunked);
        end
      end
      if (in_valid && !in_stall) begin
        took_in = 1;
        due_beats.push_back(frame_byte(in_data_byte));
      end
    end
  end

  initial begin
    int n;
    string s;
    rst_n = 0;
    in_valid = 0;
    in_data_byte = 0;
    out_stall = 0;
    errors = 0;
    beats_seen = 0;
    in_gap = 0;
    stall_left = 0;
    in_burst = 0;
    out_burst = 0;
    ph = PH_HDR;
    sub = 0;
    kpos = 0;
    kcand = 3'b111;
    rem = 0;
    len_known = 0;
    chunk_mode = 0;
    done = 0;
    bad = 0;
    scenario = $urandom_range(0, 11);
    // status line, near-miss keys, an ignored encoding
    put("HTTP/1.1 200 OK\015\012");
    put(mix_case("Content-Type: text/plain\015\012"));
    put(mix_case("Content-Lengt: 5\015\012"));
    put(mix_case("X-\015\015\012Transfer-Encodin: chunked\015\012"));
    put(mix_case("Transfer-Encoding: \tgzip\015\012"));
    put(mix_case("Transfer-Encoding: chunkedx\015\012"));
    if (scenario <= 5) begin
      put(mix_case("Transfer-Encoding:  chunked \t\015\012"));
      put(mix_case("Content-Length: 7\015\012\015\012"));
      n = 0;
      while (byte_stream.size() < 440) begin
        s = $sformatf("%0h", ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3)
                                                          : $urandom_range(1, 40));
        if ($urandom_range(0, 4) == 0) s = {"00", s};
        if (n > 0) put("\015\012");
        put(mix_case(s));
        if ($urandom_range(0, 3) == 0) put(" \t");
        put("\015\012");
        put_random(s.atohex());
        n++;
      end
      put("\015\012");
      put($urandom_range(0, 1) ? "0\015\012" : "000 \015\012");
    end else if (scenario <= 8) begin
      n = $urandom_range(250, 350);
      put(mix_case($sformatf("Content-Length: \t %0d\015\012", n)));
      put("Transfer-Encoding: chunked\015\012\015\012");
      put_random(n);
    end else if (scenario == 9) begin
      put("content-length: 4294967295\015\012\015\012");
      put_random(280);
    end else if (scenario == 10) begin
      put("Content-Length:\015\012\015\012");
      put_random(270);
    end else begin
      case ($urandom_range(0, 3))
        0: put("Content-Length: 4294967296\015\012\015\012");
        1: put("Content-Length: 12x\015\012\015\012");
        2: put("Transfer-Encoding: chunked\015\012\015\0121A;ext=1\015\012");
        default: put("Transfer-Encoding: chunked\015\012\015\012100000000\015\012");
      endcase
      put_random(300);
    end
    put_random(15);
    repeat (8) @(posedge clk);
    rst_n <= 1;
    while (byte_stream.size() > 0) @(posedge clk);
    @(posedge clk);
    while (in_valid || due_beats.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("response scenario %0d: %0d beats checked, chunked=%0b done=%0b error=%0b",
             scenario, beats_seen, chunk_mode, done, bad);
    if (errors == 0 && due_beats.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout with %0d beats outstanding", due_beats.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
